>>> rtl/core/lpt_pkg.sv
// Shared types and constants for the linear-probe get-or-add table.
// Used by lpt_front, lpt_back and linear_probe_get_or_add_table.
package lpt_pkg;

  localparam int ID_W        = 32;
  localparam int SLOT_W      = 6;
  localparam int ORD_W       = 7;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STS_FOUND   = 2'd0,
    STS_ADDED   = 2'd1,
    STS_FULL    = 2'd2,
    STS_CLEARED = 2'd3
  } status_t;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   function_id;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [ORD_W-1:0]  ordinal;
    logic              load_high;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   function_id;
  } cmd_t;

endpackage

>>> rtl/core/lpt_front.sv
// Front end: accepts input items, decodes the action and queues commands.
// Depends on lpt_pkg.
module lpt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpt_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output lpt_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  localparam int QD = lpt_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  lpt_pkg::cmd_t q_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;
  lpt_pkg::cmd_t push_cmd;

  assign in_stall  = (cnt_r == CW'(QD));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;

  always_comb begin
    push_cmd.op          = in_item.action ? lpt_pkg::OP_CLEAR : lpt_pkg::OP_LOOKUP;
    push_cmd.function_id = in_item.function_id;
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/lpt_back.sv
// Back end: slot memory, probe sequencer, clearing pass and result register.
// Depends on lpt_pkg.
module lpt_back #(
  parameter int SLOTS    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  lpt_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lpt_pkg::out_item_t out_item
);

  localparam int SW       = $clog2(SLOTS);
  localparam int OW       = lpt_pkg::ORD_W;
  localparam int EW       = 1 + OW + KEY_BITS;
  localparam int FILL_LIM = ((SLOTS - 1) * 3 + 3) / 4;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_WIPE  = 3'b100
  } state_t;

  logic [EW-1:0]       mem_r [SLOTS];
  logic [EW-1:0]       rd_data_r;

  state_t              state_r, state_nxt;
  logic [SW-1:0]       probe_r, probe_nxt;
  logic [SW-1:0]       cnt_r, cnt_nxt;
  logic [SW-1:0]       wipe_r, wipe_nxt;
  logic                clr_rsp_r, clr_rsp_nxt;
  logic [OW-1:0]       fill_r, fill_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                out_valid_r, out_valid_nxt;
  lpt_pkg::out_item_t  out_item_r;

  logic [KEY_BITS-1:0] key_cmd;
  logic [SW-1:0]       home;
  logic                rd_vld;
  logic [OW-1:0]       rd_ord;
  logic [KEY_BITS-1:0] rd_key;
  logic [OW-1:0]       fill_inc;
  logic                out_free;
  logic                fin;
  lpt_pkg::out_item_t  res;
  logic                we;
  logic [SW-1:0]       wa;
  logic [EW-1:0]       wd;

  assign key_cmd   = KEY_BITS'(cmd.function_id);
  assign home      = SW'(key_cmd);
  assign rd_vld    = rd_data_r[EW-1];
  assign rd_ord    = rd_data_r[KEY_BITS +: OW];
  assign rd_key    = rd_data_r[KEY_BITS-1:0];
  assign fill_inc  = fill_r + 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt   = state_r;
    probe_nxt   = probe_r;
    cnt_nxt     = cnt_r;
    wipe_nxt    = wipe_r;
    clr_rsp_nxt = clr_rsp_r;
    fill_nxt    = fill_r;
    key_nxt     = key_r;
    cmd_pop     = 1'b0;
    fin         = 1'b0;
    we          = 1'b0;
    wa          = probe_r;
    wd          = {1'b1, fill_inc, key_r};
    res.status  = lpt_pkg::STS_FOUND;
    res.slot    = lpt_pkg::SLOT_W'(probe_r);
    res.ordinal = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == lpt_pkg::OP_CLEAR) begin
            wipe_nxt    = '0;
            clr_rsp_nxt = 1'b1;
            state_nxt   = ST_WIPE;
          end else begin
            key_nxt   = key_cmd;
            probe_nxt = home;
            cnt_nxt   = '0;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (!rd_vld) begin
          if (out_free) begin
            we          = 1'b1;
            fill_nxt    = fill_inc;
            fin         = 1'b1;
            res.status  = lpt_pkg::STS_ADDED;
            res.ordinal = fill_inc;
            state_nxt   = ST_IDLE;
          end
        end else if (rd_key == key_r) begin
          if (out_free) begin
            fin         = 1'b1;
            res.status  = lpt_pkg::STS_FOUND;
            res.ordinal = rd_ord;
            state_nxt   = ST_IDLE;
          end
        end else if (cnt_r == SW'(SLOTS - 1)) begin
          if (out_free) begin
            fin        = 1'b1;
            res.status = lpt_pkg::STS_FULL;
            res.slot   = '0;
            state_nxt  = ST_IDLE;
          end
        end else begin
          probe_nxt = probe_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      ST_WIPE: begin
        we = 1'b1;
        wa = wipe_r;
        wd = '0;
        if (wipe_r == SW'(SLOTS - 1)) begin
          if (!clr_rsp_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            fin         = 1'b1;
            fill_nxt    = '0;
            clr_rsp_nxt = 1'b0;
            res.status  = lpt_pkg::STS_CLEARED;
            res.slot    = '0;
            state_nxt   = ST_IDLE;
          end
        end else begin
          wipe_nxt = wipe_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    res.load_high = (32'(fill_nxt) >= 32'(FILL_LIM));
    if (fin) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_data_r <= mem_r[probe_nxt];
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_item_r <= res;
    end
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      probe_r     <= '0;
      cnt_r       <= '0;
      wipe_r      <= '0;
      clr_rsp_r   <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      probe_r     <= probe_nxt;
      cnt_r       <= cnt_nxt;
      wipe_r      <= wipe_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/linear_probe_get_or_add_table.sv
// Top level of the linear-probe get-or-add table.
// Depends on lpt_pkg, lpt_front and lpt_back.
//
// Usage:
// - Input channel in_valid/in_stall/in_item carries an action (get-or-add of
//   function_id, or clear) into a two-entry command queue; in_stall is high
//   only while the queue is full.
// - Result channel out_valid/out_stall/out_item gives one item per input
//   item, in order, from an output register.
// - A lookup probes slots in turn from its home slot, at most SLOTS of them,
//   through the single-read slot memory. A clear writes one memory entry
//   per cycle.
// - After reset a clearing pass runs over the slot memory; input items are
//   queued meanwhile but not processed.
// - While out_stall holds a waiting result, the back end holds its finished
//   item in place and the queue keeps accepting until it fills.
module linear_probe_get_or_add_table #(
  parameter int SLOTS    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lpt_pkg::out_item_t out_item
);

  logic          cmd_valid;
  lpt_pkg::cmd_t cmd;
  logic          cmd_pop;

  lpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  lpt_back #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> verif/lpt_get_or_add_checker.sv
// Result checker for linear_probe_get_or_add_table: watches both channels,
// keeps its own copy of the probe table and compares every result item.
// Depends on lpt_pkg for the item types and codes.
module lpt_get_or_add_checker
  import lpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        awaiting
);

  localparam int TABLE_SLOTS = 1 << SLOT_W;

  logic [ID_W-1:0]   id_at_slot[TABLE_SLOTS];
  logic [ORD_W-1:0]  ordinal_at_slot[TABLE_SLOTS];
  bit                slot_taken[TABLE_SLOTS];
  logic [ORD_W-1:0]  entries_used = '0;
  out_item_t         expected_replies[$];
  int                mismatches = 0;
  int                outstanding = 0;

  assign fail_count = mismatches;
  assign awaiting   = outstanding;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic out_item_t predict_get_or_add(input in_item_t req);
    out_item_t        rsp;
    logic [SLOT_W-1:0] probe;
    bit               settled;
    rsp = '0;
    settled = 1'b0;
    if (req.action == OP_CLEAR) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      entries_used = '0;
      rsp.status = STS_CLEARED;
    end else begin
      rsp.status = STS_FULL;
      probe = req.function_id[SLOT_W-1:0];
      for (int n = 0; n < TABLE_SLOTS && !settled; n++) begin
        if (!slot_taken[probe]) begin
          entries_used = entries_used + 1'b1;
          slot_taken[probe] = 1'b1;
          id_at_slot[probe] = req.function_id;
          ordinal_at_slot[probe] = entries_used;
          rsp.status = STS_ADDED;
          rsp.slot = probe;
          rsp.ordinal = entries_used;
          settled = 1'b1;
        end else if (id_at_slot[probe] == req.function_id) begin
          rsp.status = STS_FOUND;
          rsp.slot = probe;
          rsp.ordinal = ordinal_at_slot[probe];
          settled = 1'b1;
        end
        probe = probe + 1'b1;
      end
    end
    rsp.load_high = (int'(entries_used) * 4 >= (TABLE_SLOTS - 1) * 3);
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("result item with none expected (status %0d)",
                                    out_item.status));
        end else begin
          want = expected_replies.pop_front();
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_item.status, want.status));
          if (out_item.slot !== want.slot)
            report_mismatch($sformatf("slot got %0d want %0d",
                                      out_item.slot, want.slot));
          if (out_item.ordinal !== want.ordinal)
            report_mismatch($sformatf("ordinal got %0d want %0d",
                                      out_item.ordinal, want.ordinal));
          if (out_item.load_high !== want.load_high)
            report_mismatch($sformatf("load_high got %0b want %0b",
                                      out_item.load_high, want.load_high));
        end
      end
      if (in_valid && !in_stall) expected_replies.push_back(predict_get_or_add(in_item));
    end
    outstanding <= expected_replies.size();
  end

endmodule

>>> verif/linear_probe_get_or_add_table_tb.sv
// Testbench top for linear_probe_get_or_add_table: drives lookups and clears
// with bursty traffic and receiver stalls, and gives the verdict.
// Depends on lpt_pkg, the block and lpt_get_or_add_checker.
module linear_probe_get_or_add_table_tb;
  import lpt_pkg::*;

  localparam int TABLE_SLOTS  = 1 << SLOT_W;
  localparam int ITEM_GOAL    = 1800;
  localparam int DRAIN_CYCLES = TABLE_SLOTS + 16;
  localparam int LONG_HOLD    = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fail_count;
  int        awaiting;
  int        items_sent = 0;
  int        burst_left = 0;
  logic [ID_W-1:0] seen_ids[$];

  linear_probe_get_or_add_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  lpt_get_or_add_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15000000;
    $display("linear_probe_get_or_add_table regression: fail");
    $finish;
  end

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic ask(input logic [ID_W-1:0] id);
    in_item_t it;
    it.action = OP_LOOKUP;
    it.function_id = id;
    send_item(it);
  endtask

  task automatic clear_table();
    in_item_t it;
    it.action = OP_CLEAR;
    it.function_id = $urandom;
    send_item(it);
  endtask

  function automatic logic [ID_W-1:0] make_id(input logic [SLOT_W-1:0] home);
    logic [ID_W-1:0] id;
    id = $urandom;
    case ($urandom_range(0, 3))
      0: ;
      1: id[SLOT_W-1:0] = home;
      2: id = $urandom_range(0, 200);
      default: begin
        id = 32'd1 << $urandom_range(0, ID_W - 1);
        if ($urandom_range(0, 1) == 0) id = ~id;
      end
    endcase
    return id;
  endfunction

  task automatic run_episode();
    int              fill_goal;
    int              steps;
    logic [SLOT_W-1:0] home;
    logic [ID_W-1:0]   id;
    clear_table();
    seen_ids.delete();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: fill_goal = $urandom_range(4, 24);
      4, 5, 6:    fill_goal = $urandom_range(25, 50);
      default:    fill_goal = $urandom_range(60, 80);
    endcase
    home = $urandom_range(0, TABLE_SLOTS - 1);
    steps = fill_goal + fill_goal / 2;
    repeat (steps) begin
      if ($urandom_range(0, 49) == 0) begin
        clear_table();
      end else if (seen_ids.size() > 0 && $urandom_range(0, 2) == 0) begin
        ask(seen_ids[$urandom_range(0, seen_ids.size() - 1)]);
      end else begin
        id = make_id(home);
        seen_ids.push_back(id);
        ask(id);
      end
    end
  endtask

  initial begin
    int lap;
    int mode;
    int span;
    int tick;
    out_stall <= 1'b0;
    tick = 0;
    for (lap = 0; ; lap++) begin
      if (lap == 6 || lap == 30) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 80);
        repeat (span) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ((tick % 7) < 3);
          endcase
          tick++;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    ask(32'h0000_0000);
    ask(32'h0000_0000);
    ask(32'hFFFF_FFFF);
    ask(32'h0000_0040);
    ask(32'h0000_007F);
    ask(32'hFFFF_FFFF);
    ask(32'h8000_0000);
    ask(32'h0000_007F);
    clear_table();
    ask(32'h0000_0040);
    ask(32'h0000_0000);
    clear_table();
    clear_table();
    ask(32'hAAAA_AAAA);
    ask(32'h5555_5555);
    ask(32'hAAAA_AAAA);

    while (items_sent < ITEM_GOAL) run_episode();

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("linear_probe_get_or_add_table regression: pass");
    end else begin
      $display("linear_probe_get_or_add_table regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lpt_pkg.sv
rtl/core/lpt_front.sv
rtl/core/lpt_back.sv
rtl/core/linear_probe_get_or_add_table.sv
verif/lpt_get_or_add_checker.sv
verif/linear_probe_get_or_add_table_tb.sv
